### hw/rtl/iou_track_capture_gate_assert.svh
// Assertion macros used by the tracker RTL
`ifndef IOU_TRACK_CAPTURE_GATE_ASSERT_SVH
`define IOU_TRACK_CAPTURE_GATE_ASSERT_SVH
// Check that a condition implies a consequence in the same cycle
`define ITCG_ASSERT_IMPLY(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle
`define ITCG_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");
`endif

### hw/rtl/itcg_pkg.sv
`default_nettype none
package itcg_pkg;
   localparam int NUM_CLASSES_DEF = 4;
   localparam int SLOTS_PER_CLASS_DEF = 4;
   localparam int COORD_BITS_DEF = 16;

   localparam logic [2:0] ST_IGNORED = 3'd0;
   localparam logic [2:0] ST_NO_SLOT = 3'd1;
   localparam logic [2:0] ST_LIMIT = 3'd2;
   localparam logic [2:0] ST_COOLDOWN = 3'd3;
   localparam logic [2:0] ST_SAVE = 3'd4;
   localparam logic [2:0] ST_TICK_KEPT = 3'd5;
   localparam logic [2:0] ST_TICK_RESET = 3'd6;

   localparam logic [1:0] REG_IOU = 2'd0;
   localparam logic [1:0] REG_QUIET = 2'd1;
   localparam logic [1:0] REG_COOL = 2'd2;
   localparam logic [1:0] REG_MAXIMG = 2'd3;

   localparam logic [16:0] IOU_RESET = 17'd19661;
   localparam logic [31:0] QUIET_RESET = 32'd5000;
   localparam logic [31:0] COOL_RESET = 32'd15000;
   localparam logic [7:0] MAXIMG_RESET = 8'd3;

   // Shared multiplier operation for one step
   typedef struct packed {
      logic [33:0] a;
      logic [33:0] b;
   } mul_req_type;
endpackage
`default_nettype wire

### hw/rtl/iou_track_capture_gate.sv
// IoU object tracker with snapshot gate. A detection walks the slots of
// its class one at a time through a sequencer that reuses one registered
// 34x34 multiplier. An inactive slot is skipped in the geometry step. An
// active slot passes geometry, then three products for the two areas and
// the intersection. When the boxes overlap, the two cross products of the
// best compare follow. After the walk come the end check, the threshold
// product, the compare and the update step. A tick runs the tick step and
// an ignored class goes straight to the result, which is held until taken.
// req_stall is high from acceptance until the result is taken.
// Registers: 0 IoU threshold (Q1.16), 1 quiet reset time, 2 save cooldown,
// 3 image limit, at byte addresses 0, 4, 8 and 12.
`default_nettype none
`include "iou_track_capture_gate_assert.svh"
module iou_track_capture_gate #(
   parameter int NUM_CLASSES = itcg_pkg::NUM_CLASSES_DEF,
   parameter int SLOTS_PER_CLASS = itcg_pkg::SLOTS_PER_CLASS_DEF,
   parameter int COORD_BITS = itcg_pkg::COORD_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_class_id,
   input  wire logic [15:0] req_box_x,
   input  wire logic [15:0] req_box_y,
   input  wire logic [15:0] req_box_w,
   input  wire logic [15:0] req_box_h,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [1:0]       rsp_slot,
   output logic             rsp_new_object,
   output logic             rsp_save_request,
   output logic [7:0]       rsp_image_number,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int TOTAL = NUM_CLASSES * SLOTS_PER_CLASS;
   localparam int SW = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
   localparam int TW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_GEOM = 4'd1;
   localparam logic [3:0] S_MA = 4'd2;
   localparam logic [3:0] S_MB = 4'd3;
   localparam logic [3:0] S_MI = 4'd4;
   localparam logic [3:0] S_UNI = 4'd5;
   localparam logic [3:0] S_X1 = 4'd6;
   localparam logic [3:0] S_X2 = 4'd7;
   localparam logic [3:0] S_THR = 4'd8;
   localparam logic [3:0] S_THW = 4'd9;
   localparam logic [3:0] S_UPD = 4'd10;
   localparam logic [3:0] S_TICK = 4'd11;
   localparam logic [3:0] S_OUT = 4'd12;

   // configuration
   logic [16:0] iou_thr_ff;
   logic [31:0] quiet_ff;
   logic [31:0] cool_ff;
   logic [7:0]  maximg_ff;
   logic        cfg_wr;
   logic [1:0]  cfg_idx;

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel & csr_penable & csr_pwrite;
   assign cfg_idx = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         iou_thr_ff <= itcg_pkg::IOU_RESET;
         quiet_ff <= itcg_pkg::QUIET_RESET;
         cool_ff <= itcg_pkg::COOL_RESET;
         maximg_ff <= itcg_pkg::MAXIMG_RESET;
      end else if (cfg_wr) begin
         case (cfg_idx)
            itcg_pkg::REG_IOU: iou_thr_ff <= csr_pwdata[16:0];
            itcg_pkg::REG_QUIET: quiet_ff <= csr_pwdata;
            itcg_pkg::REG_COOL: cool_ff <= csr_pwdata;
            itcg_pkg::REG_MAXIMG: maximg_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         itcg_pkg::REG_IOU: csr_prdata = {15'd0, iou_thr_ff};
         itcg_pkg::REG_QUIET: csr_prdata = quiet_ff;
         itcg_pkg::REG_COOL: csr_prdata = cool_ff;
         itcg_pkg::REG_MAXIMG: csr_prdata = {24'd0, maximg_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   // slot state
   logic [TOTAL-1:0]          act_ff;
   logic [4*COORD_BITS-1:0]   box_mem [TOTAL];
   logic [31:0]               last_save_ff [TOTAL];
   logic [7:0]                cnt_ff [TOTAL];
   logic [31:0]               last_det_ff;

   // item registers
   logic [3:0]            state_ff;
   logic [COORD_BITS-1:0] bx_ff, by_ff, bw_ff, bh_ff;
   logic [31:0]           now_ff;
   logic [SW:0]           idx_ff;
   logic [TW-1:0]         base_ff;
   logic [COORD_BITS:0]   iw_ff, ih_ff;
   logic                  ovl_ff;
   logic [4*COORD_BITS-1:0] sbox_ff;
   logic [67:0]           area_a_ff, inter_ff;
   logic [33:0]           uni_ff;
   logic [33:0]           best_in_ff, best_un_ff;
   logic [67:0]           cross1_ff;
   logic                  has_best_ff;
   logic [SW-1:0]         best_ff;
   logic                  match_ff;

   // result registers
   logic [2:0] o_status_ff;
   logic [1:0] o_slot_ff;
   logic       o_new_ff, o_save_ff;
   logic [7:0] o_img_ff;

   // shared multiplier
   itcg_pkg::mul_req_type mreq;
   logic [67:0] mprod;
   itcg_mul u_mul (.clock(clock), .mul_req(mreq), .mul_prod(mprod));

   logic [SW-1:0] idx_s;
   logic [TW-1:0] cur;
   logic [COORD_BITS:0] ax2, ay2, bx2, by2, ix1, iy1, ix2, iy2;
   logic [COORD_BITS-1:0] sx, sy, sw_, sh;

   assign idx_s = idx_ff[SW-1:0];
   assign cur = base_ff + TW'(idx_s);
   assign sx = sbox_ff[COORD_BITS-1:0];
   assign sy = sbox_ff[2*COORD_BITS-1:COORD_BITS];
   assign sw_ = sbox_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign sh = sbox_ff[4*COORD_BITS-1:3*COORD_BITS];
   assign ax2 = {1'b0, sx} + {1'b0, sw_};
   assign ay2 = {1'b0, sy} + {1'b0, sh};
   assign bx2 = {1'b0, bx_ff} + {1'b0, bw_ff};
   assign by2 = {1'b0, by_ff} + {1'b0, bh_ff};
   assign ix1 = (sx > bx_ff) ? {1'b0, sx} : {1'b0, bx_ff};
   assign iy1 = (sy > by_ff) ? {1'b0, sy} : {1'b0, by_ff};
   assign ix2 = (ax2 < bx2) ? ax2 : bx2;
   assign iy2 = (ay2 < by2) ? ay2 : by2;

   // operand select per step
   always_comb begin
      mreq.a = '0;
      mreq.b = '0;
      case (state_ff)
         S_MA: begin
            mreq.a = 34'(sw_);
            mreq.b = 34'(sh);
         end
         S_MB: begin
            mreq.a = 34'(bw_ff);
            mreq.b = 34'(bh_ff);
         end
         S_MI: begin
            mreq.a = 34'(iw_ff);
            mreq.b = 34'(ih_ff);
         end
         S_UNI: begin
            // intersection arrives from the multiplier this cycle
            mreq.a = mprod[33:0];
            mreq.b = best_un_ff;
         end
         S_X1: begin
            mreq.a = best_in_ff;
            mreq.b = uni_ff;
         end
         S_THR: begin
            mreq.a = 34'(iou_thr_ff);
            mreq.b = best_un_ff;
         end
         default: ;
      endcase
   end

   logic [SW-1:0] free_slot;
   logic          free_found;
   always_comb begin
      free_slot = '0;
      free_found = 1'b0;
      for (int i = SLOTS_PER_CLASS - 1; i >= 0; i--) begin
         if (!act_ff[base_ff + TW'(i)]) begin
            free_slot = SW'(i);
            free_found = 1'b1;
         end
      end
   end

   logic [SW-1:0] pick;
   logic          pick_ok;
   logic [TW-1:0] ps;
   logic [7:0]    pcnt;
   logic [31:0]   plast;
   logic          is_new;
   always_comb begin
      is_new = !match_ff;
      pick = match_ff ? best_ff : free_slot;
      pick_ok = match_ff || free_found;
      ps = base_ff + TW'(pick);
      pcnt = is_new ? 8'd0 : cnt_ff[ps];
      plast = is_new ? 32'd0 : last_save_ff[ps];
   end

   logic item_acc;
   assign item_acc = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         act_ff <= '0;
         last_det_ff <= 32'd0;
         for (int i = 0; i < TOTAL; i++) begin
            cnt_ff[i] <= 8'd0;
            last_save_ff[i] <= 32'd0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (item_acc) begin
                  bx_ff <= req_box_x[COORD_BITS-1:0];
                  by_ff <= req_box_y[COORD_BITS-1:0];
                  bw_ff <= req_box_w[COORD_BITS-1:0];
                  bh_ff <= req_box_h[COORD_BITS-1:0];
                  now_ff <= req_now_ms;
                  base_ff <= TW'(req_class_id[CW-1:0]) * TW'(SLOTS_PER_CLASS);
                  idx_ff <= '0;
                  best_in_ff <= 34'd0;
                  best_un_ff <= 34'd1;
                  has_best_ff <= 1'b0;
                  best_ff <= '0;
                  if (!req_mode) state_ff <= S_TICK;
                  else if (req_class_id >= 8'(NUM_CLASSES)) begin
                     o_status_ff <= itcg_pkg::ST_IGNORED;
                     o_slot_ff <= 2'd0;
                     o_new_ff <= 1'b0;
                     o_save_ff <= 1'b0;
                     o_img_ff <= 8'd0;
                     state_ff <= S_OUT;
                  end else state_ff <= S_GEOM;
               end
            end
            S_TICK: begin
               o_slot_ff <= 2'd0;
               o_new_ff <= 1'b0;
               o_save_ff <= 1'b0;
               o_img_ff <= 8'd0;
               o_status_ff <= itcg_pkg::ST_TICK_KEPT;
               if (last_det_ff != 32'd0 && (now_ff - last_det_ff) >= quiet_ff) begin
                  o_status_ff <= itcg_pkg::ST_TICK_RESET;
                  act_ff <= '0;
                  last_det_ff <= 32'd0;
                  for (int i = 0; i < TOTAL; i++) begin
                     cnt_ff[i] <= 8'd0;
                     last_save_ff[i] <= 32'd0;
                  end
               end
               state_ff <= S_OUT;
            end
            S_GEOM: begin
               // fetch box of the current slot; skip inactive slots
               if (idx_ff == (SW+1)'(SLOTS_PER_CLASS)) state_ff <= S_THR;
               else if (!act_ff[cur]) idx_ff <= idx_ff + (SW+1)'(1);
               else begin
                  sbox_ff <= box_mem[cur];
                  state_ff <= S_MA;
               end
            end
            S_MA: begin
               ovl_ff <= (ix2 > ix1) && (iy2 > iy1);
               iw_ff <= ix2 - ix1;
               ih_ff <= iy2 - iy1;
               state_ff <= S_MB;
            end
            S_MB: begin
               area_a_ff <= mprod;
               state_ff <= S_MI;
            end
            S_MI: begin
               uni_ff <= 34'(mprod);
               state_ff <= S_UNI;
            end
            S_UNI: begin
               inter_ff <= mprod;
               if (!ovl_ff) begin
                  idx_ff <= idx_ff + (SW+1)'(1);
                  state_ff <= S_GEOM;
               end else state_ff <= S_X1;
               // union = areaA + areaB - inter, area B is in uni_ff
               if (ovl_ff) uni_ff <= area_a_ff[33:0] + uni_ff - mprod[33:0];
            end
            S_X1: begin
               cross1_ff <= mprod;
               state_ff <= S_X2;
            end
            S_X2: begin
               // take the slot when inter * best_un > best_in * uni
               if (uni_ff != 34'd0 && cross1_ff > mprod) begin
                  best_in_ff <= inter_ff[33:0];
                  best_un_ff <= uni_ff;
                  has_best_ff <= 1'b1;
                  best_ff <= idx_s;
               end
               idx_ff <= idx_ff + (SW+1)'(1);
               state_ff <= S_GEOM;
            end
            S_THR: state_ff <= S_THW;
            S_THW: begin
               match_ff <= has_best_ff &&
                  ({best_in_ff, 16'd0} >= mprod[49:0]);
               state_ff <= S_UPD;
            end
            S_UPD: begin
               last_det_ff <= now_ff;
               o_new_ff <= 1'b0;
               o_save_ff <= 1'b0;
               o_slot_ff <= 2'd0;
               o_img_ff <= 8'd0;
               if (!pick_ok) o_status_ff <= itcg_pkg::ST_NO_SLOT;
               else begin
                  o_slot_ff <= 2'(pick);
                  o_new_ff <= is_new;
                  if (is_new) act_ff[ps] <= 1'b1;
                  cnt_ff[ps] <= pcnt;
                  last_save_ff[ps] <= plast;
                  o_img_ff <= pcnt;
                  if (pcnt >= maximg_ff) o_status_ff <= itcg_pkg::ST_LIMIT;
                  else if (plast != 32'd0 && (now_ff - plast) < cool_ff)
                     o_status_ff <= itcg_pkg::ST_COOLDOWN;
                  else begin
                     o_status_ff <= itcg_pkg::ST_SAVE;
                     o_save_ff <= 1'b1;
                     cnt_ff[ps] <= pcnt + 8'd1;
                     o_img_ff <= pcnt + 8'd1;
                     last_save_ff[ps] <= now_ff;
                  end
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // box store: written on match or allocation
   always_ff @(posedge clock) begin
      if (state_ff == S_UPD && pick_ok)
         box_mem[ps] <= {bh_ff, bw_ff, by_ff, bx_ff};
   end

   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_status = o_status_ff;
   assign rsp_slot = o_slot_ff;
   assign rsp_new_object = o_new_ff;
   assign rsp_save_request = o_save_ff;
   assign rsp_image_number = o_img_ff;

   logic unused_ok;
   assign unused_ok = ^csr_paddr[1:0];

   `ITCG_ASSERT_IMPLY(a_save_img, clock, reset, rsp_valid && rsp_save_request,
      rsp_image_number != 8'd0 && rsp_status == itcg_pkg::ST_SAVE)
   `ITCG_ASSERT_IMPLY(a_stall_busy, clock, reset, rsp_valid, req_stall)
   `ITCG_ASSERT_NEXT(a_tick_clear, clock, reset,
      state_ff == S_TICK && last_det_ff != 32'd0 && (now_ff - last_det_ff) >= quiet_ff,
      act_ff == '0)
endmodule
`default_nettype wire

### hw/rtl/itcg_mul.sv
`default_nettype none
// Registered 34x34 multiplier shared by every IoU product
module itcg_mul (
   input  wire logic clock,
   input  wire itcg_pkg::mul_req_type mul_req,
   output logic [67:0] mul_prod
);
   logic [67:0] prod_ff;
   logic [67:0] prod_in;

   assign prod_in = mul_req.a * mul_req.b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;
endmodule
`default_nettype wire

### sim/testbench.sv
module testbench;
   localparam int NCLS = 4;
   localparam int NSLOT = 4;
   localparam int NTOT = NCLS * NSLOT;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = 1'b0;
   logic [7:0]  req_class_id = '0;
   logic [15:0] req_box_x = '0, req_box_y = '0, req_box_w = '0, req_box_h = '0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [1:0]  rsp_slot;
   logic        rsp_new_object, rsp_save_request;
   logic [7:0]  rsp_image_number;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   iou_track_capture_gate u_dut (.*);

   typedef struct packed {
      logic       mode;
      logic [7:0] cls;
      logic [15:0] x, y, w, h;
      logic [31:0] now;
   } detection_type;

   typedef struct packed {
      logic [2:0] status;
      logic [1:0] slot;
      logic       is_new;
      logic       save;
      logic [7:0] img;
   } outcome_type;

   // tracker shadow state
   logic [16:0] thr_q16;
   logic [31:0] quiet_ms, cool_ms;
   logic [7:0]  img_limit;
   logic        trk_active [NTOT];
   logic [63:0] trk_box [NTOT];
   logic [31:0] trk_last_save [NTOT];
   logic [7:0]  trk_count [NTOT];
   logic [31:0] last_seen;

   outcome_type pending_outcomes[$];
   int errors = 0;
   int send_idle_pct = 0, recv_stall_pct = 0;
   int hold_off = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic void clear_tracks();
      for (int i = 0; i < NTOT; i++) begin
         trk_active[i] = 1'b0;
         trk_last_save[i] = '0;
         trk_count[i] = '0;
      end
   endfunction

   // intersection and union of two boxes; returns 0 when they do not overlap or the union is zero
   function automatic bit box_overlap(logic [63:0] a, logic [63:0] b,
                                      output logic [63:0] inter,
                                      output logic [63:0] uni);
      logic [31:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, ix1, iy1, ix2, iy2;
      ax1 = 32'(a[15:0]); ay1 = 32'(a[31:16]);
      ax2 = ax1 + 32'(a[47:32]); ay2 = ay1 + 32'(a[63:48]);
      bx1 = 32'(b[15:0]); by1 = 32'(b[31:16]);
      bx2 = bx1 + 32'(b[47:32]); by2 = by1 + 32'(b[63:48]);
      ix1 = ax1 > bx1 ? ax1 : bx1;
      iy1 = ay1 > by1 ? ay1 : by1;
      ix2 = ax2 < bx2 ? ax2 : bx2;
      iy2 = ay2 < by2 ? ay2 : by2;
      inter = '0; uni = '0;
      if (ix2 <= ix1 || iy2 <= iy1) return 1'b0;
      inter = 64'(ix2 - ix1) * 64'(iy2 - iy1);
      uni = 64'(a[47:32]) * 64'(a[63:48]) + 64'(b[47:32]) * 64'(b[63:48]) - inter;
      return uni != '0;
   endfunction

   function automatic outcome_type track_detection(detection_type d);
      outcome_type o;
      logic [63:0] box, it, un, best_in, best_un;
      logic [127:0] lhs, rhs;
      int best, pick, base, s;
      o = '0;
      if (d.mode == 1'b0) begin
         o.status = itcg_pkg::ST_TICK_KEPT;
         if (last_seen != '0 && (d.now - last_seen) >= quiet_ms) begin
            clear_tracks();
            last_seen = '0;
            o.status = itcg_pkg::ST_TICK_RESET;
         end
         return o;
      end
      if (int'(d.cls) >= NCLS) return o;
      box = {d.h, d.w, d.y, d.x};
      base = int'(d.cls) * NSLOT;
      best_in = '0; best_un = 64'd1; best = -1; pick = -1;
      last_seen = d.now;
      for (int i = 0; i < NSLOT; i++) begin
         if (trk_active[base + i] && box_overlap(trk_box[base + i], box, it, un)) begin
            lhs = 128'(it) * 128'(best_un);
            rhs = 128'(best_in) * 128'(un);
            if (lhs > rhs) begin
               best_in = it; best_un = un; best = i;
            end
         end
      end
      if (best >= 0 && 128'(best_in) * 128'(65536) >= 128'(thr_q16) * 128'(best_un)) begin
         pick = best;
         trk_box[base + pick] = box;
      end else begin
         for (int i = 0; i < NSLOT; i++) begin
            if (pick < 0 && !trk_active[base + i]) begin
               trk_active[base + i] = 1'b1;
               trk_box[base + i] = box;
               trk_last_save[base + i] = '0;
               trk_count[base + i] = '0;
               pick = i;
               o.is_new = 1'b1;
            end
         end
      end
      if (pick < 0) begin
         o.status = itcg_pkg::ST_NO_SLOT;
         return o;
      end
      s = base + pick;
      o.slot = pick[1:0];
      if (trk_count[s] >= img_limit) o.status = itcg_pkg::ST_LIMIT;
      else if (trk_last_save[s] != '0 && (d.now - trk_last_save[s]) < cool_ms)
         o.status = itcg_pkg::ST_COOLDOWN;
      else begin
         o.status = itcg_pkg::ST_SAVE;
         o.save = 1'b1;
         trk_count[s] = trk_count[s] + 8'd1;
         trk_last_save[s] = d.now;
      end
      o.img = trk_count[s];
      return o;
   endfunction

   // register write over the APB-style port
   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         itcg_pkg::REG_IOU:    thr_q16 = val[16:0];
         itcg_pkg::REG_QUIET:  quiet_ms = val;
         itcg_pkg::REG_COOL:   cool_ms = val;
         itcg_pkg::REG_MAXIMG: img_limit = val[7:0];
         default: ;
      endcase
   endtask

   // one transfer on the input channel; outcome predicted when accepted
   task automatic send_detection(detection_type d, bit has_known, outcome_type known);
      outcome_type o;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_mode, req_class_id, req_box_x, req_box_y, req_box_w, req_box_h, req_now_ms}
         <= {d.mode, d.cls, d.x, d.y, d.w, d.h, d.now};
      do @(posedge clock); while (req_stall);
      o = track_detection(d);
      if (has_known && o !== known) begin
         $display("%0t directed row: expected %h, model gives %h", $time, known, o);
         errors++;
      end
      pending_outcomes.push_back(has_known ? known : o);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_status, rsp_slot, rsp_new_object, rsp_save_request, rsp_image_number};
         if (pending_outcomes.size() == 0) begin
            $display("%0t unexpected result %h", $time, got);
            errors++;
         end else begin
            want = pending_outcomes.pop_front();
            if (got.status !== want.status)
               $display("%0t status expected %0d actual %0d", $time, want.status, got.status);
            if (got.slot !== want.slot)
               $display("%0t slot expected %0d actual %0d", $time, want.slot, got.slot);
            if (got.is_new !== want.is_new)
               $display("%0t new_object expected %0d actual %0d", $time, want.is_new,
                        got.is_new);
            if (got.save !== want.save)
               $display("%0t save_request expected %0d actual %0d", $time, want.save,
                        got.save);
            if (got.img !== want.img)
               $display("%0t image_number expected %0d actual %0d", $time, want.img, got.img);
            if (got !== want) errors++;
         end
      end
   end

   function automatic detection_type mk(int m, int c, int x, int y, int w, int h,
                                        logic [31:0] t);
      detection_type d;
      d = {1'(m), 8'(c), 16'(x), 16'(y), 16'(w), 16'(h), t};
      return d;
   endfunction

   function automatic outcome_type res(logic [2:0] st, int sl, int n, int s, int im);
      outcome_type o;
      o = {st, 2'(sl), 1'(n), 1'(s), 8'(im)};
      return o;
   endfunction

   // random detection, mostly near shared cluster points so matches happen often
   function automatic detection_type random_detection(logic [31:0] now);
      detection_type d;
      int r;
      r = int'($urandom_range(99));
      d.mode = (r >= 8);
      d.cls = (r < 14) ? 8'($urandom) : 8'($urandom_range(NCLS - 1));
      d.now = now;
      if ($urandom_range(9) == 0) begin
         d.x = 16'($urandom); d.y = 16'($urandom);
         d.w = 16'($urandom); d.h = 16'($urandom);
      end else begin
         d.x = 16'(100 * $urandom_range(3) + $urandom_range(20));
         d.y = 16'(100 * $urandom_range(2) + $urandom_range(20));
         d.w = 16'($urandom_range(90)); d.h = 16'($urandom_range(90));
      end
      return d;
   endfunction

   initial begin
      detection_type table_d [$];
      outcome_type   table_o [$];
      bit            table_k [$];
      logic [31:0]   clk_ms;
      detection_type d;

      thr_q16 = itcg_pkg::IOU_RESET; quiet_ms = itcg_pkg::QUIET_RESET;
      cool_ms = itcg_pkg::COOL_RESET;
      img_limit = itcg_pkg::MAXIMG_RESET; last_seen = '0;
      clear_tracks();
      for (int i = 0; i < NTOT; i++) trk_box[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: tick after reset, ignored class, new object, cooldown, extremes, tick reset
      table_d.push_back(mk(0, 0, 0, 0, 0, 0, 32'd100));
      table_o.push_back(res(itcg_pkg::ST_TICK_KEPT, 0, 0, 0, 0)); table_k.push_back(1'b1);
      table_d.push_back(mk(1, 'hff, 'hffff, 'hffff, 'hffff, 'hffff, 32'd200));
      table_o.push_back(res(itcg_pkg::ST_IGNORED, 0, 0, 0, 0)); table_k.push_back(1'b1);
      table_d.push_back(mk(1, 0, 10, 10, 50, 50, 32'd1000));
      table_o.push_back(res(itcg_pkg::ST_SAVE, 0, 1, 1, 1)); table_k.push_back(1'b1);
      table_d.push_back(mk(1, 0, 12, 12, 50, 50, 32'd2000));
      table_o.push_back(res(itcg_pkg::ST_COOLDOWN, 0, 0, 0, 1)); table_k.push_back(1'b1);
      table_d.push_back(mk(1, 0, 12, 12, 0, 50, 32'd2100));
      table_o.push_back(res(itcg_pkg::ST_SAVE, 1, 1, 1, 1)); table_k.push_back(1'b1);
      table_d.push_back(mk(1, 0, 'hffff, 'hffff, 'hffff, 'hffff, 32'd2200));
      table_o.push_back(res(itcg_pkg::ST_SAVE, 2, 1, 1, 1)); table_k.push_back(1'b1);
      table_d.push_back(mk(1, 0, 'hfff0, 'hfff0, 'hffff, 'hffff, 32'd2300));
      table_o.push_back('0); table_k.push_back(1'b0);
      table_d.push_back(mk(1, 0, 500, 500, 10, 10, 32'd2400));
      table_o.push_back('0); table_k.push_back(1'b0);
      table_d.push_back(mk(1, 0, 900, 900, 10, 10, 32'd2500));
      table_o.push_back('0); table_k.push_back(1'b0);
      table_d.push_back(mk(1, 0, 10, 10, 50, 50, 32'd20000));
      table_o.push_back('0); table_k.push_back(1'b0);
      table_d.push_back(mk(1, 3, 0, 0, 'hffff, 'hffff, 32'd0));
      table_o.push_back('0); table_k.push_back(1'b0);
      table_d.push_back(mk(1, 3, 0, 0, 'hffff, 'hffff, 32'd0));
      table_o.push_back('0); table_k.push_back(1'b0);
      table_d.push_back(mk(0, 'haa, 'h5555, 'haaaa, 1, 2, 32'd20100));
      table_o.push_back(res(itcg_pkg::ST_TICK_KEPT, 0, 0, 0, 0)); table_k.push_back(1'b1);
      table_d.push_back(mk(1, 1, 5, 5, 5, 5, 32'd30000));
      table_o.push_back(res(itcg_pkg::ST_SAVE, 0, 1, 1, 1)); table_k.push_back(1'b1);
      table_d.push_back(mk(0, 0, 0, 0, 0, 0, 32'hffffffff));
      table_o.push_back(res(itcg_pkg::ST_TICK_RESET, 0, 0, 0, 0)); table_k.push_back(1'b1);
      table_d.push_back(mk(1, 2, 'h8000, 'h7fff, 'h00ff, 'hff00, 32'hffffffff));
      table_o.push_back(res(itcg_pkg::ST_SAVE, 0, 1, 1, 1)); table_k.push_back(1'b1);
      for (int i = 0; i < table_d.size(); i++)
         send_detection(table_d[i], table_k[i], table_o[i]);
      drain();

      // limit case: zero image limit and a threshold that never matches
      csr_write(itcg_pkg::REG_MAXIMG, 32'd0);
      csr_write(itcg_pkg::REG_IOU, 32'd65537);
      send_detection(mk(1, 1, 0, 0, 5, 5, 32'd40000), 1'b1,
                     res(itcg_pkg::ST_LIMIT, 0, 1, 0, 0));
      send_detection(mk(1, 1, 0, 0, 5, 5, 32'd40001), 1'b1,
                     res(itcg_pkg::ST_LIMIT, 1, 1, 0, 0));
      drain();

      // random phases through several register settings
      clk_ms = 32'd50000;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            3: begin send_idle_pct = 37; recv_stall_pct = 37; end
            4: begin send_idle_pct = 0;  recv_stall_pct = 0; hold_off = 400; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         case (ph)
            0: begin
               csr_write(itcg_pkg::REG_IOU, 32'd19661);
               csr_write(itcg_pkg::REG_QUIET, 32'd5000);
               csr_write(itcg_pkg::REG_COOL, 32'd300);
               csr_write(itcg_pkg::REG_MAXIMG, 32'd3);
            end
            1: begin
               csr_write(itcg_pkg::REG_IOU, 32'd0);
               csr_write(itcg_pkg::REG_QUIET, 32'd0);
               csr_write(itcg_pkg::REG_COOL, 32'd0);
               csr_write(itcg_pkg::REG_MAXIMG, 32'd255);
            end
            2: begin
               csr_write(itcg_pkg::REG_IOU, 32'd65536);
               csr_write(itcg_pkg::REG_QUIET, 32'hffffffff);
               csr_write(itcg_pkg::REG_COOL, 32'hffffffff);
               csr_write(itcg_pkg::REG_MAXIMG, 32'd1);
            end
            3: begin
               csr_write(itcg_pkg::REG_IOU, 32'd32768);
               csr_write(itcg_pkg::REG_QUIET, 32'd800);
               csr_write(itcg_pkg::REG_COOL, 32'd150);
               csr_write(itcg_pkg::REG_MAXIMG, 32'd6);
            end
            default: begin
               csr_write(itcg_pkg::REG_IOU, 32'($urandom_range(65537)));
               csr_write(itcg_pkg::REG_QUIET, 32'($urandom_range(2000)));
               csr_write(itcg_pkg::REG_COOL, 32'($urandom_range(400)));
               csr_write(itcg_pkg::REG_MAXIMG, 32'($urandom_range(5)));
            end
         endcase
         for (int n = 0; n < 250; n++) begin
            if ($urandom_range(5) == 0) clk_ms = clk_ms + 32'($urandom_range(600));
            if ($urandom_range(300) == 0) clk_ms = $urandom;
            d = random_detection(clk_ms);
            send_detection(d, 1'b0, '0);
         end
         drain();
      end

      if (pending_outcomes.size() != 0) begin
         $display("%0t %0d results never arrived", $time, pending_outcomes.size());
         errors++;
      end
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
